FILE: rtl/bsd_pkg.sv
package bsd_pkg;

  localparam int BSD_COUNT_BITS = 16;
  localparam int MAX_RESULTS    = 4;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_count;
  } bsd_res_t;

  typedef struct packed {
    logic       illegal;
    logic [5:0] value;
  } bsd_sextet_t;

  // alphabet lookup; pad decodes as zero, codes of 128 and above are illegal
  function automatic bsd_sextet_t sextet_of(input logic [7:0] ch);
    bsd_sextet_t s;
    s.illegal = 1'b0;
    s.value   = 6'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      s.value = 6'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      s.value = 6'(ch - 8'h61 + 8'd26);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      s.value = 6'(ch - 8'h30 + 8'd52);
    end else if (ch == CHAR_PLUS) begin
      s.value = SEXTET_PLUS;
    end else if (ch == CHAR_SLASH) begin
      s.value = SEXTET_SLASH;
    end else if (ch != CHAR_PAD) begin
      s.illegal = 1'b1;
    end
    return s;
  endfunction

endpackage

FILE: rtl/bsd_if.sv
interface bsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_text;

  modport source (output valid, output symbol, output end_of_text, input ready);
  modport sink   (input valid, input symbol, input end_of_text, output ready);
endinterface

interface bsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] byte_count;
  logic        last;

  modport source (output valid, output kind, output data_byte, output byte_count,
                  output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_count,
                  input last, output ready);
endinterface

FILE: rtl/base64_stream_decoder_core.sv
// channel      dir  payload                                    handshake
// in_stream    in   symbol[7:0], end_of_text                   valid/ready
// out_stream   out  kind[1:0], data_byte[7:0], byte_count[15:0], last   valid/ready
//
// a character is registered, then decoded into up to four results held in a
// four-entry result buffer that drains one beat per cycle unless stalled.
// one character per cycle while each gives at most one result and the output
// is ready; a character completing a group holds the input while its results drain.
// rst_n is synchronous and clears the decoder state and both buffers.
// a stalled output keeps the input register full; nothing is dropped.
module base64_stream_decoder_core #(
  parameter int COUNT_BITS = bsd_pkg::BSD_COUNT_BITS
) (
  input  logic           clk,
  input  logic           rst_n,
  bsd_in_if.sink         in_stream,
  bsd_out_if.source      out_stream
);
  import bsd_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // input register
  logic       in_full_r;
  logic [7:0] in_sym_r;
  logic       in_eot_r;

  // decoder state
  logic [17:0]           sextets_r, sextets_nxt;
  logic [1:0]            pos_r, pos_nxt;
  logic                  tpad_r, tpad_nxt;
  logic                  halted_r, halted_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;

  // result buffer
  bsd_res_t   res_r [MAX_RESULTS];
  bsd_res_t   res_nxt [MAX_RESULTS];
  logic [2:0] left_r, left_nxt;

  logic        out_fire, buf_free, take;
  bsd_sextet_t sx;
  logic        active, is_pad;
  logic [1:0]  nbytes;
  logic [7:0]  byte0, byte1, byte2;
  logic [COUNT_BITS+1:0] sum;
  logic [31:0] count_wide;

  assign out_fire = out_stream.valid && out_stream.ready;
  assign buf_free = (left_r == 3'd0) || (left_r == 3'd1 && out_fire);
  assign take     = in_full_r && buf_free;
  assign in_stream.ready = !in_full_r || take;

  assign out_stream.valid      = (left_r != 3'd0);
  assign out_stream.kind       = res_r[0].kind;
  assign out_stream.data_byte  = res_r[0].data_byte;
  assign out_stream.byte_count = res_r[0].byte_count;
  assign out_stream.last       = (left_r == 3'd1);

  assign sx     = sextet_of(in_sym_r);
  assign active = !halted_r && (in_sym_r > CHAR_SPACE);
  assign is_pad = (in_sym_r == CHAR_PAD);
  assign byte0  = {sextets_r[17:12], sextets_r[11:10]};
  assign byte1  = {sextets_r[9:6], sextets_r[5:2]};
  assign byte2  = {sextets_r[1:0], sx.value};

  always_comb begin
    nbytes = 2'd0;
    if (active && !sx.illegal && pos_r == 2'd3) begin
      nbytes = is_pad ? (tpad_r ? 2'd1 : 2'd2) : 2'd3;
    end
  end

  // saturating byte count including this character's bytes
  assign sum = {2'b00, count_r} + (COUNT_BITS+2)'(nbytes);
  always_comb begin
    count_nxt = (sum > {2'b00, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_BITS-1:0];
  end
  assign count_wide = 32'(count_nxt);

  always_comb begin
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res_nxt[i] = '0;
    end
    sextets_nxt = sextets_r;
    pos_nxt     = pos_r;
    tpad_nxt    = tpad_r;
    halted_nxt  = halted_r;
    if (active) begin
      if (sx.illegal) begin
        res_nxt[0].kind = KIND_ERROR;
        n = 3'd1;
        halted_nxt = 1'b1;
      end else if (pos_r != 2'd3) begin
        sextets_nxt = {sextets_r[11:0], sx.value};
        if (pos_r == 2'd2) begin
          tpad_nxt = is_pad;
        end
        pos_nxt = pos_r + 2'd1;
      end else begin
        res_nxt[0].kind      = KIND_DATA;
        res_nxt[0].data_byte = byte0;
        res_nxt[1].data_byte = byte1;
        res_nxt[2].data_byte = is_pad ? byte1 : byte2;
        // two-byte group keeps byte1 in slot 1; one-byte group only slot 0
        n = {1'b0, nbytes};
        sextets_nxt = '0;
        tpad_nxt    = 1'b0;
        pos_nxt     = 2'd0;
      end
    end
    if (in_eot_r) begin
      res_nxt[n[1:0]].kind       = KIND_DONE;
      res_nxt[n[1:0]].data_byte  = 8'd0;
      res_nxt[n[1:0]].byte_count = (count_wide > 32'h0000_FFFF) ? 16'hFFFF
                                                                 : count_wide[15:0];
      n = n + 3'd1;
      sextets_nxt = '0;
      pos_nxt     = 2'd0;
      tpad_nxt    = 1'b0;
      halted_nxt  = 1'b0;
    end
    left_nxt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_stream.ready) begin
      in_full_r <= in_stream.valid;
    end
    if (in_stream.ready && in_stream.valid) begin
      in_sym_r <= in_stream.symbol;
      in_eot_r <= in_stream.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sextets_r <= '0;
      pos_r     <= 2'd0;
      tpad_r    <= 1'b0;
      halted_r  <= 1'b0;
      count_r   <= '0;
      left_r    <= 3'd0;
    end else if (take) begin
      sextets_r <= sextets_nxt;
      pos_r     <= pos_nxt;
      tpad_r    <= tpad_nxt;
      halted_r  <= halted_nxt;
      count_r   <= in_eot_r ? '0 : count_nxt;
      left_r    <= left_nxt;
    end else if (out_fire) begin
      left_r <= left_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        res_r[i] <= res_nxt[i];
      end
    end else if (out_fire) begin
      // shift the next beat into the head slot
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        res_r[i] <= res_r[i+1];
      end
      res_r[MAX_RESULTS-1] <= '0;
    end
  end

endmodule
